[sv/nmea_sentence_checker_unit_defines.svh]
// ----------------------------------------------------------------------------
// nmea sentence checker assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_UNIT_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define NMEA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define NMEA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NMEA_ASSERT_NOW(lbl, ante, cons, msg)
`define NMEA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[sv/nmea_chk_pkg.sv]
// ----------------------------------------------------------------------------
// nmea checker package
// character codes, status codes, result layout and hex digit helper
// ----------------------------------------------------------------------------
package nmea_chk_pkg;

    // default longest sentence length counted
    localparam int DEFAULT_MAX_SENTENCE = 255;

    // shortest sentence that can carry a checksum
    localparam logic [7:0] MIN_SENTENCE = 8'd4;

    // framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_BAD      = 2'd2
    } status_t;

    // one result item
    typedef struct packed {
        logic [7:0] received_low_char;
        logic [7:0] received_high_char;
        logic [7:0] computed_checksum;
        logic [7:0] sentence_length;
        status_t    status;
    } result_t;

    // uppercase ascii hex digit of a nibble
    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
    endfunction

endpackage

[sv/nmea_chk_core.sv]
// ----------------------------------------------------------------------------
// nmea checker sentence core
// sentence framing state, running checksum and result build for one byte
// ----------------------------------------------------------------------------
`include "nmea_sentence_checker_unit_defines.svh"

module nmea_chk_core #(
    parameter int MAX_SENTENCE = nmea_chk_pkg::DEFAULT_MAX_SENTENCE
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    output logic                  res_fire,
    output nmea_chk_pkg::result_t res
);

    localparam logic [7:0] MaxCount = 8'(MAX_SENTENCE);

    logic       in_sentence_reg, in_sentence_next;
    logic [7:0] xor_reg, xor_next;
    logic       star_reg, star_next;
    logic [7:0] count_reg, count_next;
    logic       too_long_reg, too_long_next;
    logic [7:0] recent_reg [3];
    logic [7:0] recent_next [3];

    logic       at_limit;
    logic       is_lf;
    logic [7:0] count_upd;
    logic       long_upd;
    logic [7:0] xor_upd;
    logic       star_upd;
    logic       hex_match;

    // per-byte updates of counters and checksum
    always_comb
    begin
        at_limit  = (count_reg >= MaxCount);
        is_lf     = (data_byte == nmea_chk_pkg::CH_LF);
        count_upd = at_limit ? count_reg : (count_reg + 8'd1);
        long_upd  = too_long_reg | at_limit;
        star_upd  = star_reg | (data_byte == nmea_chk_pkg::CH_STAR);
        xor_upd   = star_upd ? xor_reg : (xor_reg ^ data_byte);
    end

    // result of a line feed inside a sentence
    always_comb
    begin
        res_fire  = in_sentence_reg & is_lf;
        hex_match = (recent_reg[2] == nmea_chk_pkg::hex_upper(xor_upd[7:4])) &&
                    (recent_reg[1] == nmea_chk_pkg::hex_upper(xor_upd[3:0]));
        res.sentence_length    = count_upd;
        res.computed_checksum  = xor_upd;
        res.received_high_char = recent_reg[2];
        res.received_low_char  = recent_reg[1];
        priority if (long_upd || (count_upd < nmea_chk_pkg::MIN_SENTENCE))
            res.status = nmea_chk_pkg::STATUS_BAD;
        else if (hex_match)
            res.status = nmea_chk_pkg::STATUS_OK;
        else
            res.status = nmea_chk_pkg::STATUS_MISMATCH;
    end

    // next sentence state
    always_comb
    begin
        in_sentence_next = in_sentence_reg;
        xor_next         = xor_reg;
        star_next        = star_reg;
        count_next       = count_reg;
        too_long_next    = too_long_reg;
        recent_next      = recent_reg;
        if (step)
        begin
            if (!in_sentence_reg)
            begin
                // hunting: only a dollar opens a sentence
                if (data_byte == nmea_chk_pkg::CH_DOLLAR)
                begin
                    in_sentence_next = 1'b1;
                    count_next       = 8'd1;
                    recent_next[0]   = data_byte;
                end
            end
            else if (is_lf)
            begin
                // sentence done, back to hunting
                in_sentence_next = 1'b0;
                xor_next         = 8'h00;
                star_next        = 1'b0;
                count_next       = 8'h00;
                too_long_next    = 1'b0;
                recent_next[0]   = 8'h00;
                recent_next[1]   = 8'h00;
                recent_next[2]   = 8'h00;
            end
            else
            begin
                xor_next       = xor_upd;
                star_next      = star_upd;
                count_next     = count_upd;
                too_long_next  = long_upd;
                recent_next[0] = data_byte;
                recent_next[1] = recent_reg[0];
                recent_next[2] = recent_reg[1];
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg <= 1'b0;
            xor_reg         <= 8'h00;
            star_reg        <= 1'b0;
            count_reg       <= 8'h00;
            too_long_reg    <= 1'b0;
            recent_reg[0]   <= 8'h00;
            recent_reg[1]   <= 8'h00;
            recent_reg[2]   <= 8'h00;
        end
        else
        begin
            in_sentence_reg <= in_sentence_next;
            xor_reg         <= xor_next;
            star_reg        <= star_next;
            count_reg       <= count_next;
            too_long_reg    <= too_long_next;
            recent_reg      <= recent_next;
        end
    end

    // hunting leaves no trace of the last sentence
    `NMEA_ASSERT_NOW(a_hunt_clear, !in_sentence_reg,
        (count_reg == 8'h00) && (xor_reg == 8'h00) && !star_reg && !too_long_reg,
        "sentence state not cleared while hunting")
    // byte count stays within its range inside a sentence
    `NMEA_ASSERT_NOW(a_count_range, in_sentence_reg,
        (count_reg != 8'h00) && (count_reg <= MaxCount),
        "byte count out of range")
    // a non line feed byte keeps the sentence open
    `NMEA_ASSERT_NEXT(a_stay_open, step && in_sentence_reg && !is_lf,
        in_sentence_reg, "sentence closed without line feed")

endmodule

[sv/nmea_sentence_checker_unit.sv]
// ----------------------------------------------------------------------------
// nmea sentence checker unit
// Checks the checksum of nmea 0183 sentences in a received byte stream.
// s_* carries one received character per item; bytes are dropped until a
// dollar opens a sentence. m_* carries one result item per line feed that
// ends a sentence: status, length, computed checksum and the two received
// checksum characters. Bytes that end no sentence produce no item.
// An accepted line feed loads the input register; its result loads the
// result register when that line feed advances and is shown on m_tvalid.
// Throughput: one byte per cycle while no line feed waits on a held result;
// the checksum update and compare sit in one stage between the two registers.
// A stalled receiver holds the result; the unit keeps taking bytes that
// produce no result and stops at the next line feed until the result
// register is free.
// Reset clears the sentence state and the valid flags of both registers;
// the unit then hunts for a dollar.
// ----------------------------------------------------------------------------
`include "nmea_sentence_checker_unit_defines.svh"

module nmea_sentence_checker_unit #(
    parameter int MAX_SENTENCE = nmea_chk_pkg::DEFAULT_MAX_SENTENCE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [9:2] sentence_length,
                                   // [17:10] computed_checksum,
                                   // [25:18] received_high_char,
                                   // [33:26] received_low_char, [39:34] zero
);

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg, in_byte_next;
    logic                  out_valid_reg, out_valid_next;
    nmea_chk_pkg::result_t out_res_reg, out_res_next;

    logic                  out_free;
    logic                  advance;
    logic                  res_fire;
    nmea_chk_pkg::result_t res;

    // sentence framing and checksum
    nmea_chk_core #(
        .MAX_SENTENCE(MAX_SENTENCE)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .data_byte(in_byte_reg),
        .res_fire (res_fire),
        .res      (res)
    );

    // handshake between the two registers
    always_comb
    begin
        out_free = !out_valid_reg || m_tready;
        advance  = in_valid_reg && (!res_fire || out_free);
        s_tready = !in_valid_reg || advance;
    end

    // next values of input and result registers
    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
            in_byte_next  = s_tdata;
        end
        if (advance && res_fire)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        out_res_reg <= out_res_next;
    end

    // output item
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_res_reg};

    // an ok status means the received digits are the checksum in hex
    `NMEA_ASSERT_NOW(a_ok_digits,
        out_valid_reg && (out_res_reg.status == nmea_chk_pkg::STATUS_OK),
        (out_res_reg.received_high_char ==
            nmea_chk_pkg::hex_upper(out_res_reg.computed_checksum[7:4])) &&
        (out_res_reg.received_low_char ==
            nmea_chk_pkg::hex_upper(out_res_reg.computed_checksum[3:0])),
        "ok status with wrong checksum digits")
    // short sentences are always bad, and length never passes the limit
    `NMEA_ASSERT_NOW(a_length_rules, out_valid_reg,
        (out_res_reg.sentence_length <= 8'(MAX_SENTENCE)) &&
        ((out_res_reg.sentence_length >= nmea_chk_pkg::MIN_SENTENCE) ||
         (out_res_reg.status == nmea_chk_pkg::STATUS_BAD)),
        "result length rules broken")
    // a byte waiting in the input register is not lost or replaced
    `NMEA_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg), "input item dropped while held")

endmodule
